@@ src/sis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection solver package
// Shared constants and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int TUSER_W         = 3;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_BOUNDED   = 2'd1,
    KIND_UNBOUNDED = 2'd2
  } kind_t;

endpackage

`default_nettype wire

@@ src/sis_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection front end
// Six register stages: differences, products, determinants, sign fix,
// scaled numerators and rounding offset.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_front #(
  parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [8*COORD_WIDTH-1:0]    up_data,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output logic [3*COORD_WIDTH+2:0]         dn_nx,
  output logic [3*COORD_WIDTH+2:0]         dn_ny,
  output logic [2*COORD_WIDTH+1:0]         dn_d2,
  output logic [2*COORD_WIDTH+3:0]         dn_side
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int MKW = 2 * W + 1;
  localparam int MW  = 3 * W + 1;
  localparam int NW  = 3 * W + 3;
  localparam int D2W = 2 * W + 2;

  logic [5:0] v_r;
  logic [5:0] en;

  always_comb begin
    en[5] = !v_r[5] || dn_ready;
    for (int i = 4; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < 6; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 1: edge vectors
  logic signed [W-1:0] px, py, ex, ey, qx, qy, fx, fy;
  assign px = up_data[0*W +: W];
  assign py = up_data[1*W +: W];
  assign ex = up_data[2*W +: W];
  assign ey = up_data[3*W +: W];
  assign qx = up_data[4*W +: W];
  assign qy = up_data[5*W +: W];
  assign fx = up_data[6*W +: W];
  assign fy = up_data[7*W +: W];

  logic signed [DW-1:0] a11_r, a21_r, a12_r, a22_r, b1_r, b2_r;
  logic signed [W-1:0]  px1_r, py1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a11_r <= DW'(ex) - DW'(px);
      a21_r <= DW'(ey) - DW'(py);
      a12_r <= DW'(qx) - DW'(fx);
      a22_r <= DW'(qy) - DW'(fy);
      b1_r  <= DW'(qx) - DW'(px);
      b2_r  <= DW'(qy) - DW'(py);
      px1_r <= px;
      py1_r <= py;
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [DW-1:0] a11b_r, a21b_r;
  logic signed [W-1:0]  px2_r, py2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_r   <= PW'(a11_r) * PW'(a22_r);
      p2_r   <= PW'(a12_r) * PW'(a21_r);
      p3_r   <= PW'(b1_r) * PW'(a22_r);
      p4_r   <= PW'(a12_r) * PW'(b2_r);
      p5_r   <= PW'(a11_r) * PW'(b2_r);
      p6_r   <= PW'(b1_r) * PW'(a21_r);
      a11b_r <= a11_r;
      a21b_r <= a21_r;
      px2_r  <= px1_r;
      py2_r  <= py1_r;
    end
  end

  // stage 3: determinants
  logic signed [PW-1:0] det_r, d1_r, d2_r;
  logic signed [DW-1:0] a11c_r, a21c_r;
  logic signed [W-1:0]  px3_r, py3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      det_r  <= p1_r - p2_r;
      d1_r   <= p3_r - p4_r;
      d2_r   <= p5_r - p6_r;
      a11c_r <= a11b_r;
      a21c_r <= a21b_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
    end
  end

  // stage 4: make the determinant positive, take magnitudes
  logic                 dneg;
  logic [MKW-1:0]       dn_r, md1_r;
  logic signed [PW-1:0] d1n_r, d2n_r;
  logic [W-1:0]         ma_r, ma2_r;
  logic                 sa_r, sa2_r, par4_r;
  logic signed [W-1:0]  px4_r, py4_r;

  assign dneg = det_r[PW-1];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dn_r   <= MKW'(dneg ? -det_r : det_r);
      d1n_r  <= dneg ? -d1_r : d1_r;
      d2n_r  <= dneg ? -d2_r : d2_r;
      md1_r  <= MKW'(d1_r[PW-1] ? -d1_r : d1_r);
      ma_r   <= W'(a11c_r[DW-1] ? -a11c_r : a11c_r);
      ma2_r  <= W'(a21c_r[DW-1] ? -a21c_r : a21c_r);
      sa_r   <= a11c_r[DW-1];
      sa2_r  <= a21c_r[DW-1];
      par4_r <= (det_r == '0);
      px4_r  <= px3_r;
      py4_r  <= py3_r;
    end
  end

  // stage 5: offset products and crossing kind
  logic [MW-1:0]       mx_r, my_r;
  logic [MKW-1:0]      dn5_r;
  logic                negx5_r, negy5_r;
  sis_pkg::kind_t      kind5_r, kind_nxt;
  logic signed [W-1:0] px5_r, py5_r;
  logic                bounded;

  always_comb begin
    bounded = !d1n_r[PW-1] && (MKW'(d1n_r) <= dn_r)
           && !d2n_r[PW-1] && (MKW'(d2n_r) <= dn_r);
    if (par4_r) begin
      kind_nxt = sis_pkg::KIND_NONE;
    end else if (bounded) begin
      kind_nxt = sis_pkg::KIND_BOUNDED;
    end else begin
      kind_nxt = sis_pkg::KIND_UNBOUNDED;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mx_r    <= MW'(ma_r) * MW'(md1_r);
      my_r    <= MW'(ma2_r) * MW'(md1_r);
      dn5_r   <= dn_r;
      negx5_r <= sa_r ^ d1n_r[PW-1];
      negy5_r <= sa2_r ^ d1n_r[PW-1];
      kind5_r <= kind_nxt;
      px5_r   <= px4_r;
      py5_r   <= py4_r;
    end
  end

  // stage 6: numerators with the rounding half step folded in
  logic [NW-1:0]       nx_r, ny_r;
  logic [D2W-1:0]      d2r_r;
  logic                negx6_r, negy6_r;
  sis_pkg::kind_t      kind6_r;
  logic signed [W-1:0] px6_r, py6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      nx_r    <= (NW'(mx_r) << 1) + NW'(dn5_r) - NW'(negx5_r);
      ny_r    <= (NW'(my_r) << 1) + NW'(dn5_r) - NW'(negy5_r);
      d2r_r   <= D2W'(dn5_r) << 1;
      negx6_r <= negx5_r;
      negy6_r <= negy5_r;
      kind6_r <= kind5_r;
      px6_r   <= px5_r;
      py6_r   <= py5_r;
    end
  end

  assign dn_valid = v_r[5];
  assign dn_nx    = nx_r;
  assign dn_ny    = ny_r;
  assign dn_d2    = d2r_r;
  assign dn_side  = {kind6_r, negy6_r, negx6_r, py6_r, px6_r};

endmodule

`default_nettype wire

@@ src/sis_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection divider step
// One restoring step for both coordinates against the shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_div_stage #(
  parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH_DEF,
  parameter int SHIFT       = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire logic [3*COORD_WIDTH+2:0]  up_rx,
  input  wire logic [3*COORD_WIDTH+2:0]  up_ry,
  input  wire logic [2*COORD_WIDTH+1:0]  up_d2,
  input  wire logic [COORD_WIDTH:0]      up_qx,
  input  wire logic [COORD_WIDTH:0]      up_qy,
  input  wire logic [2*COORD_WIDTH+3:0]  up_side,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output logic [3*COORD_WIDTH+2:0]       dn_rx,
  output logic [3*COORD_WIDTH+2:0]       dn_ry,
  output logic [2*COORD_WIDTH+1:0]       dn_d2,
  output logic [COORD_WIDTH:0]           dn_qx,
  output logic [COORD_WIDTH:0]           dn_qy,
  output logic [2*COORD_WIDTH+3:0]       dn_side
);

  localparam int NW = 3 * COORD_WIDTH + 3;

  logic          v_r;
  logic          en;
  logic [NW-1:0] dk;
  logic          gex, gey;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dk       = NW'(up_d2) << SHIFT;
  assign gex      = (up_rx >= dk);
  assign gey      = (up_ry >= dk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rx   <= gex ? up_rx - dk : up_rx;
      dn_ry   <= gey ? up_ry - dk : up_ry;
      dn_d2   <= up_d2;
      dn_qx   <= {up_qx[COORD_WIDTH-1:0], gex};
      dn_qy   <= {up_qy[COORD_WIDTH-1:0], gey};
      dn_side <= up_side;
    end
  end

  assign dn_valid = v_r;

endmodule

`default_nettype wire

@@ src/sis_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection back end
// Apply sign, add the base point, saturate and hold the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_back #(
  parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [COORD_WIDTH:0]        up_qx,
  input  wire logic [COORD_WIDTH:0]        up_qy,
  input  wire logic [2*COORD_WIDTH+3:0]    up_side,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output sis_pkg::kind_t                   out_kind,
  output logic [COORD_WIDTH-1:0]           out_x,
  output logic [COORD_WIDTH-1:0]           out_y,
  output logic                             out_ovf
);

  localparam int W = COORD_WIDTH;
  localparam int VW = W + 2;
  localparam logic signed [VW-1:0] HI = VW'((1 << (W - 1)) - 1);
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  logic                v_r;
  logic                en;
  logic signed [W-1:0] px, py;
  logic                negx, negy;
  sis_pkg::kind_t      kind;
  logic [W-1:0]        x_nxt, y_nxt;
  logic                ox, oy;

  assign px   = up_side[0 +: W];
  assign py   = up_side[W +: W];
  assign negx = up_side[2*W];
  assign negy = up_side[2*W+1];
  assign kind = sis_pkg::kind_t'(up_side[2*W+3 -: 2]);

  function automatic logic [W:0] place(input logic signed [W-1:0] base,
                                       input logic [W:0] q, input logic neg);
    logic signed [VW-1:0] off;
    logic signed [VW-1:0] v;
    logic [W:0]           res;
    off = VW'({1'b0, q[W-1:0]});
    v   = VW'(base) + (neg ? -off : off);
    if (q[W]) begin
      res = {1'b1, W'(neg ? LO : HI)};
    end else if (v > HI) begin
      res = {1'b1, W'(HI)};
    end else if (v < LO) begin
      res = {1'b1, W'(LO)};
    end else begin
      res = {1'b0, W'(v)};
    end
    return res;
  endfunction

  assign {ox, x_nxt} = place(px, up_qx, negx);
  assign {oy, y_nxt} = place(py, up_qy, negy);

  assign en       = !v_r || out_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind <= kind;
      // parallel lines report a zero point
      if (kind == sis_pkg::KIND_NONE) begin
        out_x   <= '0;
        out_y   <= '0;
        out_ovf <= 1'b0;
      end else begin
        out_x   <= x_nxt;
        out_y   <= y_nxt;
        out_ovf <= ox | oy;
      end
    end
  end

  assign out_valid = v_r;

endmodule

`default_nettype wire

@@ src/segment_intersection_solver_unit.sv @@
`timescale 1ns / 1ps
// Register stages from input request to result: six front stages,
// COORD_WIDTH + 1 restoring divider steps and the output register.
// Throughput: one request per cycle unless stalled; every divider step is its own stage.
// Stalls hold each stage in place; empty stages fill while the output waits.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Segment intersection solver
// Cramer's rule crossing of two segments, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_solver_unit #(
  parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  wire logic [((8*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // cross_x, cross_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]         out_tdata,
  // kind, overflow
  output logic [sis_pkg::TUSER_W-1:0]                out_tuser
);

  localparam int W   = COORD_WIDTH;
  localparam int NW  = 3 * W + 3;
  localparam int D2W = 2 * W + 2;
  localparam int SW  = 2 * W + 4;
  localparam int NS  = W + 1;
  localparam int OTW = ((2 * W + 7) / 8) * 8;

  logic            v_w   [0:NS];
  logic            rdy_w [0:NS];
  logic [NW-1:0]   rx_w  [0:NS];
  logic [NW-1:0]   ry_w  [0:NS];
  logic [D2W-1:0]  d2_w  [0:NS];
  logic [W:0]      qx_w  [0:NS];
  logic [W:0]      qy_w  [0:NS];
  logic [SW-1:0]   sd_w  [0:NS];

  sis_front #(.COORD_WIDTH(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata[8*W-1:0]),
    .dn_valid (v_w[0]),
    .dn_ready (rdy_w[0]),
    .dn_nx    (rx_w[0]),
    .dn_ny    (ry_w[0]),
    .dn_d2    (d2_w[0]),
    .dn_side  (sd_w[0])
  );

  assign qx_w[0] = '0;
  assign qy_w[0] = '0;

  // quotient bits from the top; the first step flags saturation
  for (genvar k = 0; k < NS; k++) begin : g_div
    sis_div_stage #(.COORD_WIDTH(W), .SHIFT(W - k)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_w[k]),
      .up_ready (rdy_w[k]),
      .up_rx    (rx_w[k]),
      .up_ry    (ry_w[k]),
      .up_d2    (d2_w[k]),
      .up_qx    (qx_w[k]),
      .up_qy    (qy_w[k]),
      .up_side  (sd_w[k]),
      .dn_valid (v_w[k+1]),
      .dn_ready (rdy_w[k+1]),
      .dn_rx    (rx_w[k+1]),
      .dn_ry    (ry_w[k+1]),
      .dn_d2    (d2_w[k+1]),
      .dn_qx    (qx_w[k+1]),
      .dn_qy    (qy_w[k+1]),
      .dn_side  (sd_w[k+1])
    );
  end

  sis_pkg::kind_t kind;
  logic [W-1:0]   cx, cy;
  logic           ovf;

  sis_back #(.COORD_WIDTH(W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v_w[NS]),
    .up_ready  (rdy_w[NS]),
    .up_qx     (qx_w[NS]),
    .up_qy     (qy_w[NS]),
    .up_side   (sd_w[NS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_x     (cx),
    .out_y     (cy),
    .out_ovf   (ovf)
  );

  assign out_tdata = OTW'({cy, cx});
  assign out_tuser = {ovf, kind};

  localparam logic [W-1:0] CHI = W'((1 << (W - 1)) - 1);
  localparam logic [W-1:0] CLO = ~CHI;

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (kind == sis_pkg::KIND_NONE || kind == sis_pkg::KIND_BOUNDED
                    || kind == sis_pkg::KIND_UNBOUNDED))
    else $error("illegal crossing kind");

  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && kind == sis_pkg::KIND_NONE) |-> (cx == '0 && cy == '0 && !ovf))
    else $error("parallel result not zero");

  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ovf) |-> (cx == CHI || cx == CLO || cy == CHI || cy == CLO))
    else $error("overflow without a clamped coordinate");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline refuses requests while output is empty");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection solver testbench
// Drives segment pairs over the input stream and checks every crossing
// result against an exact Cramer's rule predictor, with random idling on
// both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int CW        = 16;
  localparam int LATENCY   = CW + 8;
  localparam int MAX_CYCLE = 400000;

  typedef struct {
    sis_pkg::kind_t  kind;
    logic [CW-1:0]   cx;
    logic [CW-1:0]   cy;
    logic            ovf;
  } crossing_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [8*CW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [2*CW-1:0] out_tdata;
  logic [sis_pkg::TUSER_W-1:0] out_tuser;

  crossing_t crossing_q[$];
  int errors;
  int cycles;
  bit rx_idle_en;
  bit tx_idle_en;
  int hold_off;

  segment_intersection_solver_unit #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // base + round(a * n / d), half toward plus infinity, d > 0
  function automatic logic signed [95:0] round_place(longint base, longint a, longint n,
                                                     longint d);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] q;
    num = 2 * ($signed(128'(a)) * $signed(128'(n))) + d;
    den = 2 * $signed(128'(d));
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return $signed(128'(base)) + q;
  endfunction

  function automatic crossing_t solve_crossing(logic [8*CW-1:0] seg);
    crossing_t r;
    longint px, py, ex, ey, qx, qy, fx, fy;
    longint a11, a21, a12, a22, b1, b2, det, d1, d2;
    logic signed [95:0] vx, vy;
    longint hi, lo;
    px = $signed(seg[0*CW +: CW]); py = $signed(seg[1*CW +: CW]);
    ex = $signed(seg[2*CW +: CW]); ey = $signed(seg[3*CW +: CW]);
    qx = $signed(seg[4*CW +: CW]); qy = $signed(seg[5*CW +: CW]);
    fx = $signed(seg[6*CW +: CW]); fy = $signed(seg[7*CW +: CW]);
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    r.kind = sis_pkg::KIND_NONE; r.cx = '0; r.cy = '0; r.ovf = 1'b0;
    a11 = ex - px; a21 = ey - py;
    a12 = qx - fx; a22 = qy - fy;
    b1 = qx - px; b2 = qy - py;
    det = a11 * a22 - a12 * a21;
    if (det == 0) return r;
    d1 = b1 * a22 - a12 * b2;
    d2 = a11 * b2 - b1 * a21;
    if (det < 0) begin
      det = -det; d1 = -d1; d2 = -d2;
    end
    vx = round_place(px, a11, d1, det);
    vy = round_place(py, a21, d1, det);
    if (vx > hi) begin vx = hi; r.ovf = 1'b1; end
    if (vx < lo) begin vx = lo; r.ovf = 1'b1; end
    if (vy > hi) begin vy = hi; r.ovf = 1'b1; end
    if (vy < lo) begin vy = lo; r.ovf = 1'b1; end
    r.kind = (d1 >= 0 && d1 <= det && d2 >= 0 && d2 <= det) ?
             sis_pkg::KIND_BOUNDED : sis_pkg::KIND_UNBOUNDED;
    r.cx = vx[CW-1:0];
    r.cy = vy[CW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // send one request, random gap first
  task automatic send_segments(logic [8*CW-1:0] seg);
    while (tx_idle_en && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seg;
    crossing_q.push_back(solve_crossing(seg));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic finish_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return CW'($signed($urandom_range(200)) - 100);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [8*CW-1:0] pack_seg(int v0, int v1, int v2, int v3,
                                               int v4, int v5, int v6, int v7);
    return {CW'(v7), CW'(v6), CW'(v5), CW'(v4), CW'(v3), CW'(v2), CW'(v1), CW'(v0)};
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (crossing_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = crossing_q.pop_front();
        if (out_tuser[1:0] != want.kind) report_mismatch("kind", out_tuser[1:0], want.kind);
        if (out_tuser[2] != want.ovf) report_mismatch("overflow", out_tuser[2], want.ovf);
        if (out_tdata[CW-1:0] != want.cx) report_mismatch("cross_x", out_tdata[CW-1:0], want.cx);
        if (out_tdata[2*CW-1:CW] != want.cy)
          report_mismatch("cross_y", out_tdata[2*CW-1:CW], want.cy);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_idle_en && $urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("[segment_intersection_solver_unit] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    logic [CW-1:0] mx;
    logic [CW-1:0] mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_segments(pack_seg(0, 0, 32, 32, 0, 32, 32, 0));            // bounded cross
    send_segments(pack_seg(0, 0, 16, 16, 32, 0, 48, 16));           // parallel
    send_segments(pack_seg(0, 0, 16, 16, 32, 32, 48, 48));          // collinear
    send_segments(pack_seg(5, 5, 5, 5, 0, 0, 16, 7));               // degenerate point
    send_segments(pack_seg(0, 0, 16, 0, 64, -16, 64, 16));          // unbounded
    send_segments(pack_seg(0, 0, 16, 0, 16, -16, 16, 16));          // touches end
    send_segments(pack_seg(0, 0, 1, 0, 0, 1, 3, 1));                // parallel close
    send_segments(pack_seg(0, 0, 3, 1, 1, 0, 1, 3));                // half rounding
    send_segments(pack_seg(0, 0, 3, 1, -1, 0, -1, 3));
    send_segments(pack_seg(0, 0, 2, 1, 1, 0, 1, 3));
    send_segments(pack_seg(0, 0, -2, 1, -1, 0, -1, 3));
    send_segments(pack_seg(mn, mn, mx, mx, mn, mx, mx, mn));        // extremes
    send_segments(pack_seg(mx, 0, mx - 1, 1, mn, 0, mn, 1));       // overflow y
    send_segments(pack_seg(0, 0, 1, 1, 1, mx, 0, mx));              // far crossing
    send_segments(pack_seg(0, mn, 1, mn + 1, mx, 0, mx - 1, 0));
    send_segments(pack_seg(mx, mx, mx, mx, mx, mx, mx, mx));
    send_segments(pack_seg(-1, -1, -1, -1, -1, -1, -1, -1));
    send_segments(pack_seg(mn, mx, mx, mn, mn, mn, mx, mx));
    send_segments(pack_seg(0, 0, 16, 1, 0, 16, 16, 15));
    finish_sending();
  endtask

  task automatic test_random(int n);
    logic [8*CW-1:0] seg;
    for (int i = 0; i < n; i++) begin
      seg = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(2) == 0) begin
        for (int k = 0; k < 8; k++) seg[k*CW +: CW] = rand_coord();
      end else if ($urandom_range(4) == 0) begin
        // make the second segment parallel to the first
        seg[6*CW +: CW] = seg[4*CW +: CW] + (seg[2*CW +: CW] - seg[0*CW +: CW]);
        seg[7*CW +: CW] = seg[5*CW +: CW] + (seg[3*CW +: CW] - seg[1*CW +: CW]);
      end
      send_segments(seg);
    end
    finish_sending();
  endtask

  task automatic test_backpressure();
    hold_off <= 200;
    test_random(80);
    // drain fully before carrying on
    while (crossing_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_no_idle();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(200);
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(400);
    test_no_idle();
    test_random(400);
    while (crossing_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("[segment_intersection_solver_unit] OK");
    end else begin
      $display("[segment_intersection_solver_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
